/* rtl/core/irhl_pkg.sv */
// ----------------------------------------------------------------------------
// irhl_pkg
// Shared types, codes and the helper function of the instance memory block:
// operation codes, controller states, memory address selects, the command and
// status bundles between controller and datapath, and the handle hash fold.
// ----------------------------------------------------------------------------
package irhl_pkg;

  localparam int unsigned WINDOW_BASE_DEF  = 32'd7340032;
  localparam int unsigned WINDOW_BYTES_DEF = 32'd1048576;
  localparam int unsigned PROBE_LIMIT_DEF  = 32'd16;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 160;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_DMA    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD_ISSUE,
    ST_RD_CAP,
    ST_LK_START,
    ST_LK_HANDLE,
    ST_LK_CTX,
    ST_LK_TEST,
    ST_LK_CLASS,
    ST_LK_CLASS_CAP,
    ST_DMA_START,
    ST_DMA_W0,
    ST_DMA_W1,
    ST_DMA_W2,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    ADDR_BUS,
    ADDR_HANDLE,
    ADDR_HANDLE_NEXT,
    ADDR_CTX,
    ADDR_CLASS,
    ADDR_DMA0,
    ADDR_DMA1,
    ADDR_DMA2
  } addr_sel_e;

  typedef struct packed {
    logic      load_in;
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_e addr_sel;
    logic      cap_read;
    logic      cap_hmatch;
    logic      init_probe;
    logic      advance;
    logic      cap_inst;
    logic      cap_class;
    logic      cap_dma0;
    logic      cap_dma1;
    logic      cap_dma2;
    logic      set_err;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic bus_ok;
    logic table_ok;
    logic dma_ok;
    logic hit;
    logic last_probe;
  } sts_t;

  // Fold a handle into chunks of 11 + code bits and XOR them together.
  function automatic logic [13:0] irhl_fold(input logic [31:0] handle,
                                            input logic [1:0]  code);
    logic [13:0] res;
    res = '0;
    unique case (code)
      2'd0: res = {3'b0, handle[10:0] ^ handle[21:11] ^ {1'b0, handle[31:22]}};
      2'd1: res = {2'b0, handle[11:0] ^ handle[23:12] ^ {4'b0, handle[31:24]}};
      2'd2: res = {1'b0, handle[12:0] ^ handle[25:13] ^ {7'b0, handle[31:26]}};
      2'd3: res = handle[13:0] ^ handle[27:14] ^ {10'b0, handle[31:28]};
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

/* rtl/core/instance_ram_hash_lookup.sv */
// ----------------------------------------------------------------------------
// instance_ram_hash_lookup
// Instance memory of 32-bit words behind a bus window, with word read and
// write, object handle hash lookup with linear probing, and DMA object decode.
// ----------------------------------------------------------------------------
// One item is worked at a time through a single-port instance memory with a
// registered read. A write updates the memory word when the offset lies in
// the window and gives no result. A read issues the access and captures the
// word. A DMA decode checks the offset, then reads three words in turn; an
// offset out of range goes straight to the result. A lookup checks that the
// table fits the window, then reads the handle and context words of each
// probe until a valid entry matches or ProbeLimit probes (16 by default) are
// done, and on a hit reads the class word. Input is taken again the cycle
// after the result is loaded; a result not yet taken holds the block in its
// final step only when the next result is ready. Memory contents are undefined
// after reset; a word must be written before it is read. The table register
// may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module instance_ram_hash_lookup import irhl_pkg::*; #(
  parameter int unsigned WindowBase  = WINDOW_BASE_DEF,
  parameter int unsigned WindowBytes = WINDOW_BYTES_DEF,
  parameter int unsigned ProbeLimit  = PROBE_LIMIT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [31:0]           cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // bus_offset, write_value, object_handle, channel, instance_offset, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // read_data, found_instance, found_class, dma_word_first, dma_word_second,
  // dma_word_third, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic                  m_axis_tuser
);

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] read_data;
  logic [19:0] found_instance;
  logic [7:0]  found_class;
  logic [31:0] dma_word_first;
  logic [31:0] dma_word_second;
  logic [31:0] dma_word_third;

  assign cfg_ready_o = 1'b1;

  irhl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  irhl_dp #(
    .WindowBase  (WindowBase),
    .WindowBytes (WindowBytes),
    .ProbeLimit  (ProbeLimit)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .bus_offset_i      (s_axis_tdata[23:0]),
    .write_value_i     (s_axis_tdata[55:24]),
    .object_handle_i   (s_axis_tdata[87:56]),
    .channel_i         (s_axis_tdata[92:88]),
    .instance_offset_i (s_axis_tdata[112:93]),
    .status_o          (m_axis_tuser),
    .read_data_o       (read_data),
    .found_instance_o  (found_instance),
    .found_class_o     (found_class),
    .dma_word_first_o  (dma_word_first),
    .dma_word_second_o (dma_word_second),
    .dma_word_third_o  (dma_word_third)
  );

  assign m_axis_tdata = {4'b0, dma_word_third, dma_word_second, dma_word_first,
                         found_class, found_instance, read_data};

endmodule

/* rtl/core/irhl_dp.sv */
// ----------------------------------------------------------------------------
// irhl_dp
// Datapath: table register, item fields, instance memory, hash and probe
// index, range checks, result registers and output register.
// ----------------------------------------------------------------------------
module irhl_dp import irhl_pkg::*; #(
  parameter int unsigned WindowBase  = WINDOW_BASE_DEF,
  parameter int unsigned WindowBytes = WINDOW_BYTES_DEF,
  parameter int unsigned ProbeLimit  = PROBE_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_data_i,
  input  logic [23:0] bus_offset_i,
  input  logic [31:0] write_value_i,
  input  logic [31:0] object_handle_i,
  input  logic [4:0]  channel_i,
  input  logic [19:0] instance_offset_i,
  output logic        status_o,
  output logic [31:0] read_data_o,
  output logic [19:0] found_instance_o,
  output logic [7:0]  found_class_o,
  output logic [31:0] dma_word_first_o,
  output logic [31:0] dma_word_second_o,
  output logic [31:0] dma_word_third_o
);

  localparam int unsigned MemWords = WindowBytes / 4;
  localparam int unsigned AW       = $clog2(MemWords);
  localparam int unsigned PW       = $clog2(ProbeLimit + 1);

  logic [31:0] cfg_q;
  logic [23:0] bus_q;
  logic [31:0] wval_q;
  logic [31:0] handle_q;
  logic [4:0]  chan_q;
  logic [19:0] inst_in_q;

  logic [31:0] mem_q [MemWords];
  logic [31:0] rdata_q;

  logic [11:0]   ent_q;
  logic [PW-1:0] probe_q;
  logic          hmatch_q;

  logic        res_status_q;
  logic [31:0] res_read_q;
  logic [19:0] res_inst_q;
  logic [7:0]  res_class_q;
  logic [31:0] res_w0_q;
  logic [31:0] res_w1_q;
  logic [31:0] res_w2_q;

  logic [1:0]  code;
  logic [23:0] rel;
  logic        bus_ok;
  logic [16:0] table_off;
  logic [20:0] table_size;
  logic        table_ok;
  logic        dma_ok;
  logic        cls_ok;
  logic [13:0] fold;
  logic [11:0] mask;
  logic [11:0] hash;
  logic [11:0] ent_nxt;
  logic [19:0] tbl_word;
  logic [19:0] ent_word;
  logic [19:0] ent_word_nxt;
  logic [19:0] dma_word;
  logic [19:0] addr_full;
  logic [AW-1:0] addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  assign code       = cfg_q[17:16];
  assign rel        = bus_q - 24'(WindowBase);
  assign bus_ok     = (bus_q >= 24'(WindowBase)) && (rel <= 24'(WindowBytes - 4));
  assign table_off  = {cfg_q[8:4], 12'b0};
  assign table_size = 21'd1 << (5'(code) + 5'd12);
  assign table_ok   = ({4'b0, table_off} + table_size) <= 21'(WindowBytes);
  assign dma_ok     = {1'b0, inst_in_q} <= 21'(WindowBytes - 12);
  assign cls_ok     = {1'b0, res_inst_q} <= 21'(WindowBytes - 4);

  assign fold    = irhl_fold(handle_q, code);
  assign mask    = (12'd1 << (5'(code) + 5'd9)) - 12'd1;
  assign hash    = (fold[11:0] ^ (12'(chan_q) << (5'(code) + 5'd7))) & mask;
  assign ent_nxt = (ent_q + 12'd1) & mask;

  assign tbl_word     = {5'b0, cfg_q[8:4], 10'b0};
  assign ent_word     = tbl_word + {7'b0, ent_q, 1'b0};
  assign ent_word_nxt = tbl_word + {7'b0, ent_nxt, 1'b0};
  assign dma_word     = {2'b0, inst_in_q[19:2]};

  always_comb begin
    addr_full = '0;
    unique case (cmd_i.addr_sel)
      ADDR_BUS:         addr_full = 20'(rel[23:2]);
      ADDR_HANDLE:      addr_full = ent_word;
      ADDR_HANDLE_NEXT: addr_full = ent_word_nxt;
      ADDR_CTX:         addr_full = ent_word + 20'd1;
      ADDR_CLASS:       addr_full = {2'b0, res_inst_q[19:2]};
      ADDR_DMA0:        addr_full = dma_word;
      ADDR_DMA1:        addr_full = dma_word + 20'd1;
      ADDR_DMA2:        addr_full = dma_word + 20'd2;
      default:          addr_full = '0;
    endcase
  end

  assign addr = addr_full[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[addr] <= wval_q;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      bus_q     <= bus_offset_i;
      wval_q    <= write_value_i;
      handle_q  <= object_handle_i;
      chan_q    <= channel_i;
      inst_in_q <= instance_offset_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_probe) begin
      ent_q   <= hash;
      probe_q <= '0;
    end else if (cmd_i.advance) begin
      ent_q   <= ent_nxt;
      probe_q <= probe_q + PW'(1);
    end
    if (cmd_i.cap_hmatch) begin
      hmatch_q <= (rdata_q == handle_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      res_status_q <= 1'b0;
      res_read_q   <= '0;
      res_inst_q   <= '0;
      res_class_q  <= '0;
      res_w0_q     <= '0;
      res_w1_q     <= '0;
      res_w2_q     <= '0;
    end else begin
      if (cmd_i.cap_read) begin
        res_status_q <= !bus_ok;
        res_read_q   <= bus_ok ? rdata_q : 32'd0;
      end
      if (cmd_i.set_err) begin
        res_status_q <= 1'b1;
      end
      if (cmd_i.cap_inst) begin
        res_inst_q <= {rdata_q[15:0], 4'b0};
      end
      if (cmd_i.cap_class) begin
        res_class_q <= cls_ok ? rdata_q[7:0] : 8'd0;
      end
      if (cmd_i.cap_dma0) begin
        res_w0_q <= rdata_q;
      end
      if (cmd_i.cap_dma1) begin
        res_w1_q <= rdata_q;
      end
      if (cmd_i.cap_dma2) begin
        res_w2_q <= rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o          <= res_status_q;
      read_data_o       <= res_read_q;
      found_instance_o  <= res_inst_q;
      found_class_o     <= res_class_q;
      dma_word_first_o  <= res_w0_q;
      dma_word_second_o <= res_w1_q;
      dma_word_third_o  <= res_w2_q;
    end
  end

  assign sts_o.bus_ok     = bus_ok;
  assign sts_o.table_ok   = table_ok;
  assign sts_o.dma_ok     = dma_ok;
  assign sts_o.hit        = hmatch_q && rdata_q[31];
  assign sts_o.last_probe = (probe_q == PW'(ProbeLimit - 1));

endmodule

/* rtl/core/irhl_ctrl.sv */
// ----------------------------------------------------------------------------
// irhl_ctrl
// Controller: sequences memory accesses of each operation, drives the
// datapath commands and owns the input ready and output valid handshakes.
// ----------------------------------------------------------------------------
module irhl_ctrl import irhl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cmd_t       cmd_o,
  input  sts_t       sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_e'(op_i))
            OP_READ:   state_d = ST_RD_ISSUE;
            OP_WRITE:  state_d = ST_WRITE;
            OP_LOOKUP: state_d = ST_LK_START;
            OP_DMA:    state_d = ST_DMA_START;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRITE:    state_d = ST_IDLE;
      ST_RD_ISSUE: state_d = ST_RD_CAP;
      ST_RD_CAP:   state_d = ST_DONE;
      ST_LK_START: state_d = sts_i.table_ok ? ST_LK_HANDLE : ST_DONE;
      ST_LK_HANDLE: state_d = ST_LK_CTX;
      ST_LK_CTX:   state_d = ST_LK_TEST;
      ST_LK_TEST: begin
        priority if (sts_i.hit) begin
          state_d = ST_LK_CLASS;
        end else if (sts_i.last_probe) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_LK_CTX;
        end
      end
      ST_LK_CLASS:     state_d = ST_LK_CLASS_CAP;
      ST_LK_CLASS_CAP: state_d = ST_DONE;
      ST_DMA_START:    state_d = sts_i.dma_ok ? ST_DMA_W0 : ST_DONE;
      ST_DMA_W0:       state_d = ST_DMA_W1;
      ST_DMA_W1:       state_d = ST_DMA_W2;
      ST_DMA_W2:       state_d = ST_DONE;
      ST_DONE:         state_d = out_free ? ST_IDLE : ST_DONE;
      default:         state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.addr_sel = ADDR_BUS;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_WRITE: begin
        cmd_o.mem_wr = sts_i.bus_ok;
      end
      ST_RD_ISSUE: begin
        cmd_o.mem_rd = sts_i.bus_ok;
      end
      ST_RD_CAP: begin
        cmd_o.cap_read = 1'b1;
      end
      ST_LK_START: begin
        cmd_o.init_probe = 1'b1;
        cmd_o.set_err    = !sts_i.table_ok;
      end
      ST_LK_HANDLE: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = ADDR_HANDLE;
      end
      ST_LK_CTX: begin
        cmd_o.mem_rd     = 1'b1;
        cmd_o.addr_sel   = ADDR_CTX;
        cmd_o.cap_hmatch = 1'b1;
      end
      ST_LK_TEST: begin
        priority if (sts_i.hit) begin
          cmd_o.cap_inst = 1'b1;
        end else if (sts_i.last_probe) begin
          cmd_o.set_err = 1'b1;
        end else begin
          cmd_o.advance  = 1'b1;
          cmd_o.mem_rd   = 1'b1;
          cmd_o.addr_sel = ADDR_HANDLE_NEXT;
        end
      end
      ST_LK_CLASS: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = ADDR_CLASS;
      end
      ST_LK_CLASS_CAP: begin
        cmd_o.cap_class = 1'b1;
      end
      ST_DMA_START: begin
        cmd_o.set_err  = !sts_i.dma_ok;
        cmd_o.mem_rd   = sts_i.dma_ok;
        cmd_o.addr_sel = ADDR_DMA0;
      end
      ST_DMA_W0: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = ADDR_DMA1;
        cmd_o.cap_dma0 = 1'b1;
      end
      ST_DMA_W1: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = ADDR_DMA2;
        cmd_o.cap_dma1 = 1'b1;
      end
      ST_DMA_W2: begin
        cmd_o.cap_dma2 = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for instance_ram_hash_lookup. Drives random reads,
// writes, handle lookups and DMA decodes over the streaming ports. Before
// each item, the words that the item will read are written first. Each
// accepted item goes to a scoreboard that keeps its own copy of instance
// memory and of the table register. Results are checked field by field, in
// order. Random idle cycles on both sides, one long output stall, and table
// settings from the smallest to the largest table.
// ----------------------------------------------------------------------------
module tb;
  import irhl_pkg::*;

  localparam int unsigned WinBase     = WINDOW_BASE_DEF;
  localparam int unsigned WinBytes    = WINDOW_BYTES_DEF;
  localparam int unsigned ProbeMax    = PROBE_LIMIT_DEF;
  localparam int unsigned LastWordRel = WinBytes - 4;
  localparam int unsigned DmaMaxOff   = WinBytes - 12;
  localparam int unsigned HotBytes    = 16384;
  localparam int unsigned Settle      = 64;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned ItemTarget  = 1150;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned MaxReports  = 100;
  localparam logic [31:0] CtxValid    = 32'h8000_0000;

  typedef struct {
    op_e         op;
    logic [23:0] bus_offset;
    logic [31:0] write_value;
    logic [31:0] object_handle;
    logic [4:0]  channel;
    logic [19:0] instance_offset;
  } mem_item_t;

  typedef struct {
    logic        status;
    logic [31:0] read_data;
    logic [19:0] found_instance;
    logic [7:0]  found_class;
    logic [31:0] dma_first;
    logic [31:0] dma_second;
    logic [31:0] dma_third;
  } mem_result_t;

  class inst_mem_scoreboard;
    bit [31:0]   words [int unsigned];
    bit [31:0]   table_reg;
    mem_result_t expected_q [$];
    int          errors;
    int          missing_word;

    function void set_table(bit [31:0] value);
      table_reg = value;
    endfunction

    function int unsigned table_base();
      return {15'b0, table_reg[8:4], 12'b0};
    endfunction

    function int unsigned table_entries();
      return 32'd512 << table_reg[17:16];
    endfunction

    function int unsigned probe_home(bit [31:0] handle, bit [4:0] chan);
      int unsigned width_bits;
      int unsigned hash;
      int unsigned rest;
      width_bits = 11 + table_reg[17:16];
      hash = 0;
      rest = handle;
      while (rest != 0) begin
        hash ^= rest & ((32'd1 << width_bits) - 1);
        rest >>= width_bits;
      end
      hash ^= 32'(chan) << (width_bits - 4);
      return hash & (table_entries() - 1);
    endfunction

    function int unsigned entry_rel(int unsigned home, int unsigned slot);
      return table_base() + ((home + slot) & (table_entries() - 1)) * 8;
    endfunction

    function bit [31:0] fetch(int unsigned rel, output bit ok);
      ok = (rel <= LastWordRel);
      if (!ok) return 32'd0;
      if (!words.exists(rel >> 2)) begin
        if (missing_word < 0) missing_word = rel >> 2;
        return 32'd0;
      end
      return words[rel >> 2];
    endfunction

    function mem_result_t evaluate(mem_item_t it);
      mem_result_t r;
      bit          ok;
      bit [31:0]   hval;
      bit [31:0]   ctx;
      bit [31:0]   word;
      int unsigned home;
      int unsigned erel;
      int unsigned tsize;
      int unsigned limit;
      r = '{default: '0};
      missing_word = -1;
      ok = 1'b0;
      case (it.op)
        OP_READ: begin
          if (it.bus_offset >= WinBase) r.read_data = fetch(it.bus_offset - WinBase, ok);
          r.status = !ok;
        end
        OP_LOOKUP: begin
          r.status = 1'b1;
          tsize = 32'd4096 << table_reg[17:16];
          limit = (ProbeMax < table_entries()) ? ProbeMax : table_entries();
          if (table_base() <= WinBytes && tsize <= WinBytes - table_base()) begin
            home = probe_home(it.object_handle, it.channel);
            for (int unsigned p = 0; p < limit; p++) begin
              erel = entry_rel(home, p);
              hval = fetch(erel, ok);
              ctx  = fetch(erel + 4, ok);
              if (hval == it.object_handle && (ctx & CtxValid) != 0) begin
                r.status = 1'b0;
                r.found_instance = {ctx[15:0], 4'b0};
                word = fetch({12'b0, ctx[15:0], 4'b0}, ok);
                r.found_class = word[7:0];
                break;
              end
            end
          end
        end
        OP_DMA: begin
          if (it.instance_offset > DmaMaxOff) begin
            r.status = 1'b1;
          end else begin
            r.dma_first  = fetch(it.instance_offset, ok);
            r.dma_second = fetch(it.instance_offset + 4, ok);
            r.dma_third  = fetch(it.instance_offset + 8, ok);
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_item(mem_item_t it);
      mem_result_t r;
      int unsigned rel;
      r = evaluate(it);
      if (it.op == OP_WRITE) begin
        if (it.bus_offset >= WinBase) begin
          rel = it.bus_offset - WinBase;
          if (rel <= LastWordRel) words[rel >> 2] = it.write_value;
        end
      end else begin
        expected_q.push_back(r);
      end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(mem_result_t got);
      mem_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected result: expected none, actual status %b data %h",
                   $time, got.status, got.read_data);
        return;
      end
      want = expected_q.pop_front();
      compare("status", 32'(want.status), 32'(got.status));
      compare("read_data", want.read_data, got.read_data);
      compare("found_instance", 32'(want.found_instance), 32'(got.found_instance));
      compare("found_class", 32'(want.found_class), 32'(got.found_class));
      compare("dma_word_first", want.dma_first, got.dma_first);
      compare("dma_word_second", want.dma_second, got.dma_second);
      compare("dma_word_third", want.dma_third, got.dma_third);
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [31:0]           cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  inst_mem_scoreboard sb = new();
  int          planned_items = 0;
  int          tx_calm       = 0;
  int          rx_calm       = 0;
  int          rx_hold       = 0;
  int          quiet_cycles  = 0;
  logic [31:0] handle_pool [16];

  instance_ram_hash_lookup u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  initial begin : result_sink
    int          gap;
    mem_result_t got;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end else begin
        gap = draw_gap(rx_calm);
      end
      @(negedge clk_i);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.status         = m_axis_tuser;
      got.read_data      = m_axis_tdata[31:0];
      got.found_instance = m_axis_tdata[51:32];
      got.found_class    = m_axis_tdata[59:52];
      got.dma_first      = m_axis_tdata[91:60];
      got.dma_second     = m_axis_tdata[123:92];
      got.dma_third      = m_axis_tdata[155:124];
      sb.check_result(got);
    end
  end

  task automatic send_item(input mem_item_t it);
    int gap;
    gap = draw_gap(tx_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {7'b0, it.instance_offset, it.channel, it.object_handle,
                      it.write_value, it.bus_offset};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
    planned_items++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic write_table(input logic [31:0] value);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_table(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic mem_item_t random_item(op_e op);
    mem_item_t it;
    it.op              = op;
    it.bus_offset      = 24'($urandom);
    it.write_value     = $urandom;
    it.object_handle   = $urandom;
    it.channel         = 5'($urandom);
    it.instance_offset = 20'($urandom);
    return it;
  endfunction

  function automatic mem_item_t make_item(op_e op, logic [23:0] bus, logic [31:0] value,
                                          logic [31:0] handle, logic [4:0] chan,
                                          logic [19:0] inst);
    mem_item_t it;
    it.op              = op;
    it.bus_offset      = bus;
    it.write_value     = value;
    it.object_handle   = handle;
    it.channel         = chan;
    it.instance_offset = inst;
    return it;
  endfunction

  function automatic int unsigned pick_rel();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom_range(0, HotBytes - 1);
    if (sel < 6) return sb.table_base() + $urandom_range(0, sb.table_entries() * 8 - 1);
    if (sel < 9) return $urandom_range(0, WinBytes - 1);
    return $urandom_range(WinBytes - 16, WinBytes - 1);
  endfunction

  function automatic logic [23:0] pick_bus();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 24'($urandom_range(0, WinBase - 1));
    if (sel == 1) return 24'($urandom_range(WinBase + WinBytes, 24'hFF_FFFF));
    if (sel == 2) return 24'($urandom);
    return 24'(WinBase + pick_rel());
  endfunction

  task automatic write_word(input int unsigned rel, input logic [31:0] value);
    mem_item_t it;
    it = random_item(OP_WRITE);
    it.bus_offset  = 24'(WinBase + rel + ((rel < LastWordRel) ? $urandom_range(0, 3) : 0));
    it.write_value = value;
    send_item(it);
  endtask

  // write every word the item would read before the item itself
  task automatic apply_item(input mem_item_t it);
    mem_result_t unused;
    forever begin
      unused = sb.evaluate(it);
      if (sb.missing_word < 0) break;
      write_word(sb.missing_word * 4, $urandom);
    end
    send_item(it);
  endtask

  task automatic place_entry(input logic [31:0] handle, input logic [4:0] chan,
                             input int unsigned slot, input bit valid,
                             input logic [15:0] obj);
    int unsigned erel;
    erel = sb.entry_rel(sb.probe_home(handle, chan), slot);
    write_word(erel, handle);
    write_word(erel + 4, {valid, 15'($urandom), obj});
  endtask

  task automatic random_step();
    mem_item_t   it;
    int unsigned sel;
    int unsigned off;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      it = random_item(OP_WRITE);
      it.bus_offset = pick_bus();
    end else if (sel < 40) begin
      it = random_item(OP_READ);
      it.bus_offset = pick_bus();
    end else if (sel < 85) begin
      it = random_item(OP_LOOKUP);
      if ($urandom_range(0, 3) != 0) it.object_handle = handle_pool[$urandom_range(0, 15)];
      else handle_pool[$urandom_range(0, 15)] = it.object_handle;
      if ($urandom_range(0, 9) < 6)
        place_entry(it.object_handle, it.channel, $urandom_range(0, ProbeMax - 1),
                    $urandom_range(0, 9) != 0, 16'(pick_rel() >> 4));
    end else begin
      it = random_item(OP_DMA);
      off = pick_rel();
      if (off > DmaMaxOff) off -= 12;
      if ($urandom_range(0, 9) == 0) off = $urandom_range(DmaMaxOff + 1, WinBytes - 1);
      it.instance_offset = 20'(off);
    end
    apply_item(it);
  endtask

  initial begin
    logic [31:0] settings [NumPhases];
    settings = '{32'hFFFF_FFFF, 32'h0001_0010, $urandom, 32'h0003_0000, $urandom,
                 32'h0002_01F0};
    for (int i = 0; i < 16; i++) handle_pool[i] = $urandom;
    handle_pool[0] = 32'h0000_0000;
    handle_pool[1] = 32'hFFFF_FFFF;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    write_table(32'h0000_0000);
    apply_item(make_item(OP_WRITE, 24'(WinBase), 32'hFFFF_FFFF, 32'h0, 5'd0, 20'h0));
    apply_item(make_item(OP_READ, 24'(WinBase + 3), 32'h0, 32'h0, 5'd0, 20'h0));
    apply_item(make_item(OP_WRITE, 24'(WinBase + LastWordRel), 32'h0, 32'h0, 5'd0, 20'h0));
    apply_item(make_item(OP_READ, 24'(WinBase + LastWordRel), 32'h0, 32'h0, 5'd0, 20'h0));
    apply_item(make_item(OP_READ, 24'(WinBase + WinBytes - 1), 32'h0, 32'h0, 5'd0, 20'h0));
    apply_item(make_item(OP_READ, 24'h00_0000, 32'h0, 32'h0, 5'd0, 20'h0));
    apply_item(make_item(OP_READ, 24'hFF_FFFF, 32'h0, 32'h0, 5'd0, 20'h0));
    apply_item(make_item(OP_READ, 24'(WinBase - 1), 32'h0, 32'h0, 5'd0, 20'h0));
    apply_item(make_item(OP_WRITE, 24'hFF_FFFF, 32'h1234_5678, 32'h0, 5'd0, 20'h0));
    apply_item(make_item(OP_WRITE, 24'h00_0000, 32'h8765_4321, 32'h0, 5'd0, 20'h0));
    apply_item(make_item(OP_READ, 24'(WinBase), 32'h0, 32'h0, 5'd0, 20'h0));
    apply_item(make_item(OP_DMA, 24'h0, 32'h0, 32'h0, 5'd0, 20'h0_0000));
    apply_item(make_item(OP_DMA, 24'h0, 32'h0, 32'h0, 5'd0, 20'(DmaMaxOff)));
    apply_item(make_item(OP_DMA, 24'h0, 32'h0, 32'h0, 5'd0, 20'(DmaMaxOff + 1)));
    apply_item(make_item(OP_DMA, 24'h0, 32'h0, 32'h0, 5'd0, 20'hF_FFFF));
    place_entry(32'hFFFF_FFFF, 5'd31, 0, 1'b1, 16'hFFFF);
    apply_item(make_item(OP_LOOKUP, 24'h0, 32'h0, 32'hFFFF_FFFF, 5'd31, 20'h0));
    place_entry(32'h0000_0000, 5'd0, ProbeMax - 1, 1'b1, 16'h0000);
    apply_item(make_item(OP_LOOKUP, 24'h0, 32'h0, 32'h0000_0000, 5'd0, 20'h0));
    apply_item(make_item(OP_LOOKUP, 24'h0, 32'h0, 32'h1234_5678, 5'd5, 20'h0));
    place_entry(32'hDEAD_BEEF, 5'd7, 3, 1'b0, 16'h0040);
    apply_item(make_item(OP_LOOKUP, 24'h0, 32'h0, 32'hDEAD_BEEF, 5'd7, 20'h0));
    apply_item(make_item(OP_LOOKUP, 24'h0, 32'h0, 32'hFFFF_FFFF, 5'd30, 20'h0));

    for (int i = 0; i < NumPhases; i++) begin
      write_table(settings[i]);
      if (i == 1) rx_hold = LongHold;
      while (planned_items < ItemTarget * (i + 1) / NumPhases) random_step();
    end

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
